// ===== hdl/pzbi_pkg.sv =====
`default_nettype none

package pzbi_pkg;

   localparam int LIMIT_COUNT  = 7;
   localparam int ZONE_W       = 3;
   localparam int LIMIT_W      = 11;
   localparam int HYST_W       = 6;
   localparam int POWER_W      = 16;
   localparam int POWER_X_W    = 18;
   localparam int CADENCE_W    = 8;
   localparam int TIME_W       = 32;
   localparam int COLOR_W      = 8;
   localparam int RGB_W        = 24;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 11;
   localparam int ALU_W        = 34;
   localparam int QUOT_W       = 11;
   localparam int STEP_W       = 4;

   localparam logic [15:0]          MINUTE_MS    = 16'd60000;
   localparam logic [TIME_W-1:0]    LIT_MS       = 32'd100;
   localparam logic [CADENCE_W-1:0] SLOW_CADENCE = 8'd30;
   localparam logic [CADENCE_W-1:0] FALLBACK_RPM = 8'd60;
   localparam logic [CADENCE_W-1:0] REM_START    = CADENCE_W'(MINUTE_MS >> QUOT_W);

   localparam logic [CSR_IDX_W-1:0] CSR_ZONE_LIMIT_1 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HYSTERESIS   = 3'd7;

   localparam logic [HYST_W-1:0] HYST_RESET = 6'd5;

   typedef logic [LIMIT_W-1:0] limit_type;
   typedef limit_type [LIMIT_COUNT-1:0] limit_array_type;

   localparam limit_array_type LIMIT_RESET = {
      11'd345, 11'd310, 11'd276, 11'd242, 11'd207, 11'd173, 11'd127
   };

   typedef struct packed {
      limit_array_type   limit;
      logic [HYST_W-1:0] hyst;
   } cfg_type;

   typedef enum logic [2:0] {
      ALU_ZONE,
      ALU_DIV,
      ALU_NEED,
      ALU_ELAP,
      ALU_CMP
   } alu_op_type;

   typedef struct packed {
      limit_type                     limit;
      logic signed [POWER_X_W-1:0]   power;
      logic [CADENCE_W:0]            rem_shift;
      logic [CADENCE_W-1:0]          rpm;
      logic [QUOT_W-1:0]             period;
      logic [TIME_W-1:0]             now;
      logic [TIME_W-1:0]             mark;
      logic [TIME_W-1:0]             elapsed;
      logic [TIME_W-1:0]             need;
   } alu_in_type;

   typedef struct packed {
      logic [ALU_W-1:0] diff;
      logic             neg;
   } alu_out_type;

   function automatic logic [RGB_W-1:0] zone_color(input logic [ZONE_W-1:0] zone);
      logic [RGB_W-1:0] rgb;
      unique case (zone)
         3'd0: rgb = 24'h969696;
         3'd1: rgb = 24'h0000FF;
         3'd2: rgb = 24'h00FF00;
         3'd3: rgb = 24'h8B4513;
         3'd4: rgb = 24'hFFC800;
         3'd5: rgb = 24'hFF6400;
         3'd6: rgb = 24'h8B0000;
         3'd7: rgb = 24'h800080;
         default: rgb = '0;
      endcase
      return rgb;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/pzbi_if.sv =====
`default_nettype none

interface pzbi_req_if
   import pzbi_pkg::*;
   ();
   logic                        valid;
   logic                        ready;
   logic                        mode;
   logic signed [POWER_W-1:0]   power_watts;
   logic [CADENCE_W-1:0]        cadence_rpm;
   logic [TIME_W-1:0]           now_ms;

   modport source (output valid, mode, power_watts, cadence_rpm, now_ms, input ready);
   modport sink   (input valid, mode, power_watts, cadence_rpm, now_ms, output ready);
endinterface

interface pzbi_rsp_if
   import pzbi_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [ZONE_W-1:0]    zone;
   logic                 lamp_on;
   logic [COLOR_W-1:0]   red;
   logic [COLOR_W-1:0]   green;
   logic [COLOR_W-1:0]   blue;
   logic                 show_strobe;

   modport source (output valid, zone, lamp_on, red, green, blue, show_strobe, input ready);
   modport sink   (input valid, zone, lamp_on, red, green, blue, show_strobe, output ready);
endinterface

`default_nettype wire

// ===== hdl/pzbi_sub.sv =====
`default_nettype none

module pzbi_sub
   import pzbi_pkg::*;
(
   input  alu_op_type  op,
   input  alu_in_type  opnd,
   output alu_out_type res
);

   logic [ALU_W-1:0] a;
   logic [ALU_W-1:0] b;

   always_comb begin
      unique case (op)
         ALU_ZONE: begin
            a = ALU_W'(opnd.limit);
            b = {{(ALU_W-POWER_X_W){opnd.power[POWER_X_W-1]}}, opnd.power};
         end
         ALU_DIV: begin
            a = ALU_W'(opnd.rem_shift);
            b = ALU_W'(opnd.rpm);
         end
         ALU_NEED: begin
            a = ALU_W'(opnd.period);
            b = ALU_W'(LIT_MS);
         end
         ALU_ELAP: begin
            a = ALU_W'(opnd.now);
            b = ALU_W'(opnd.mark);
         end
         ALU_CMP: begin
            a = ALU_W'(opnd.elapsed);
            b = ALU_W'(opnd.need);
         end
         default: begin
            a = '0;
            b = '0;
         end
      endcase
      res.diff = a - b;
      res.neg  = res.diff[ALU_W-1];
   end

endmodule

`default_nettype wire

// ===== hdl/pzbi_ctrl.sv =====
`default_nettype none

module pzbi_ctrl
   import pzbi_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   pzbi_req_if.sink         req_chan,
   pzbi_rsp_if.source       rsp_chan
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_ZONE,
      S_DIV,
      S_NEED,
      S_ELAP,
      S_CMP,
      S_FIN
   } state_type;

   state_type                    state_ff;
   logic                         dark_req_ff;
   logic signed [POWER_X_W-1:0]  power_ff;
   logic signed [POWER_X_W-1:0]  power_h_ff;
   logic [CADENCE_W-1:0]         rpm_ff;
   logic [TIME_W-1:0]            now_ff;
   logic [STEP_W-1:0]            cnt_ff;
   logic [ZONE_W-1:0]            zone_ff;
   logic [CADENCE_W-1:0]         rem_ff;
   logic [QUOT_W-1:0]            quot_ff;
   logic [TIME_W-1:0]            need_ff;
   logic [TIME_W-1:0]            elapsed_ff;
   logic                         fire_ff;

   logic [ZONE_W-1:0]            held_zone_ff;
   logic [TIME_W-1:0]            blink_mark_ff;
   logic                         lit_phase_ff;
   logic                         dark_shown_ff;
   logic [RGB_W-1:0]             pixel_ff;

   logic                         rsp_valid_ff;
   logic [ZONE_W-1:0]            rsp_zone_ff;
   logic                         rsp_lamp_ff;
   logic [RGB_W-1:0]             rsp_rgb_ff;
   logic                         rsp_strobe_ff;

   logic                         lit_in;
   logic [RGB_W-1:0]             pixel_in;
   logic                         strobe_in;
   logic                         dark_shown_in;
   logic [ZONE_W-1:0]            zone_in;
   logic [TIME_W-1:0]            mark_in;

   alu_op_type                   op;
   alu_in_type                   opnd;
   alu_out_type                  res;
   logic [ZONE_W-1:0]            lim_idx;
   logic                         slot_free;
   logic                         accept;

   assign accept    = req_chan.valid && req_chan.ready;
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign lim_idx   = cnt_ff[ZONE_W-1:0] - ZONE_W'(1);

   always_comb begin
      unique case (state_ff)
         S_ZONE:  op = ALU_ZONE;
         S_DIV:   op = ALU_DIV;
         S_NEED:  op = ALU_NEED;
         S_ELAP:  op = ALU_ELAP;
         default: op = ALU_CMP;
      endcase
      opnd.limit     = cfg.limit[lim_idx];
      opnd.power     = (held_zone_ff == cnt_ff[ZONE_W-1:0]) ? power_h_ff : power_ff;
      opnd.rem_shift = {rem_ff, MINUTE_MS[cnt_ff]};
      opnd.rpm       = rpm_ff;
      opnd.period    = quot_ff;
      opnd.now       = now_ff;
      opnd.mark      = blink_mark_ff;
      opnd.elapsed   = elapsed_ff;
      opnd.need      = need_ff;
   end

   pzbi_sub u_sub (
      .op   (op),
      .opnd (opnd),
      .res  (res)
   );

   always_comb begin
      zone_in       = held_zone_ff;
      lit_in        = lit_phase_ff;
      mark_in       = blink_mark_ff;
      pixel_in      = pixel_ff;
      dark_shown_in = dark_shown_ff;
      strobe_in     = 1'b0;
      if (dark_req_ff) begin
         if (!dark_shown_ff) begin
            pixel_in      = '0;
            dark_shown_in = 1'b1;
            strobe_in     = 1'b1;
         end
      end else begin
         zone_in       = zone_ff;
         dark_shown_in = 1'b0;
         if (fire_ff) begin
            mark_in   = now_ff;
            lit_in    = !lit_phase_ff;
            pixel_in  = lit_phase_ff ? '0 : zone_color(zone_ff);
            strobe_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         held_zone_ff  <= '0;
         blink_mark_ff <= '0;
         lit_phase_ff  <= 1'b0;
         dark_shown_ff <= 1'b1;
         pixel_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_chan.ready && state_ff != S_FIN) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  dark_req_ff <= req_chan.mode;
                  power_ff    <= POWER_X_W'(req_chan.power_watts);
                  power_h_ff  <= POWER_X_W'(req_chan.power_watts)
                                 + POWER_X_W'(cfg.hyst);
                  rpm_ff      <= (req_chan.cadence_rpm > SLOW_CADENCE) ?
                                 req_chan.cadence_rpm : FALLBACK_RPM;
                  now_ff      <= req_chan.now_ms;
                  cnt_ff      <= STEP_W'(LIMIT_COUNT);
                  state_ff    <= req_chan.mode ? S_FIN : S_ZONE;
               end
            end
            S_ZONE: begin
               if (res.neg || cnt_ff == STEP_W'(1)) begin
                  zone_ff  <= res.neg ? cnt_ff[ZONE_W-1:0] : '0;
                  cnt_ff   <= STEP_W'(QUOT_W - 1);
                  rem_ff   <= REM_START;
                  state_ff <= S_DIV;
               end else begin
                  cnt_ff <= cnt_ff - STEP_W'(1);
               end
            end
            S_DIV: begin
               quot_ff <= {quot_ff[QUOT_W-2:0], !res.neg};
               rem_ff  <= res.neg ? opnd.rem_shift[CADENCE_W-1:0] : res.diff[CADENCE_W-1:0];
               if (cnt_ff == '0) begin
                  state_ff <= S_NEED;
               end else begin
                  cnt_ff <= cnt_ff - STEP_W'(1);
               end
            end
            S_NEED: begin
               need_ff  <= lit_phase_ff ? LIT_MS : res.diff[TIME_W-1:0];
               state_ff <= S_ELAP;
            end
            S_ELAP: begin
               elapsed_ff <= res.diff[TIME_W-1:0];
               state_ff   <= S_CMP;
            end
            S_CMP: begin
               fire_ff  <= !res.neg;
               state_ff <= S_FIN;
            end
            S_FIN: begin
               if (slot_free) begin
                  held_zone_ff  <= zone_in;
                  blink_mark_ff <= mark_in;
                  lit_phase_ff  <= lit_in;
                  dark_shown_ff <= dark_shown_in;
                  pixel_ff      <= pixel_in;
                  rsp_valid_ff  <= 1'b1;
                  rsp_zone_ff   <= zone_in;
                  rsp_lamp_ff   <= lit_in;
                  rsp_rgb_ff    <= pixel_in;
                  rsp_strobe_ff <= strobe_in;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_chan.ready       = (state_ff == S_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.zone        = rsp_zone_ff;
   assign rsp_chan.lamp_on     = rsp_lamp_ff;
   assign rsp_chan.red         = rsp_rgb_ff[23:16];
   assign rsp_chan.green       = rsp_rgb_ff[15:8];
   assign rsp_chan.blue        = rsp_rgb_ff[7:0];
   assign rsp_chan.show_strobe = rsp_strobe_ff;

   a_pixel_lit: assert property (@(posedge clock) disable iff (reset)
      (pixel_ff != '0) |-> (lit_phase_ff && !dark_shown_ff))
      else $error("pixel lit while phase dark or blanked");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (rem_ff < rpm_ff))
      else $error("divider remainder out of range");

   a_hold_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN && rsp_valid_ff && !rsp_chan.ready) |=>
      ($stable(held_zone_ff) && $stable(pixel_ff) && state_ff == S_FIN))
      else $error("state committed while result slot full");

   a_dark_strobe: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN && slot_free && dark_req_ff && strobe_in) |=>
      (dark_shown_ff && pixel_ff == '0))
      else $error("dark request did not blank pixel");

endmodule

`default_nettype wire

// ===== hdl/power_zone_blink_indicator_unit.sv =====
// Power zone blink indicator.
// req_chan carries one call per beat: mode (0 update, 1 go dark), signed power,
// cadence and a free-running millisecond time. rsp_chan returns exactly one
// beat per call: held zone, lamp phase, pixel RGB and a strobe when the pixel
// was rewritten. csr_we/csr_index/csr_wdata write zone limits 1..7 (index 0..6)
// and the hysteresis (index 7); write only while no call is in flight.
// An update runs from acceptance to rsp valid as a zone search through one
// shared subtractor (highest zone first), an 11-step restoring divide of
// 60000 by the cadence (or by 60 rpm at 30 rpm and below) on that same
// subtractor, then phase length, elapsed time and compare. A go-dark call
// skips these steps and goes straight to the result. One call is in flight
// at a time: a new call is accepted only once the last has committed, and
// req_chan.ready rises in the same cycle as rsp valid.
// The result sits in an output register, so the next call is accepted while it
// waits; if rsp_chan stalls, a finished call holds in its last step and
// commits nothing until the register frees up.
// Reset (synchronous) restores default limits, zone 0, phase dark, mark 0 and
// a blanked pixel.
`default_nettype none

module power_zone_blink_indicator_unit
   import pzbi_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   pzbi_req_if.sink               req_chan,
   pzbi_rsp_if.source             rsp_chan,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   limit_array_type    limit_ff;
   logic [HYST_W-1:0]  hyst_ff;
   cfg_type            cfg;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
         hyst_ff  <= HYST_RESET;
      end else if (csr_we) begin
         if (csr_index == CSR_HYSTERESIS) begin
            hyst_ff <= csr_wdata[HYST_W-1:0];
         end else begin
            limit_ff[csr_index - CSR_ZONE_LIMIT_1] <= csr_wdata[LIMIT_W-1:0];
         end
      end
   end

   assign cfg.limit = limit_ff;
   assign cfg.hyst  = hyst_ff;

   pzbi_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

// ===== tb/pzbi_call_pkg.sv =====
`timescale 1ns / 1ps

package pzbi_call_pkg;

   typedef enum logic {
      CALL_UPDATE = 1'b0,
      CALL_DARK   = 1'b1
   } call_mode_type;

endpackage

// ===== tb/pzbi_call_checker.sv =====
`timescale 1ns / 1ps

module pzbi_call_checker
   import pzbi_pkg::*;
   import pzbi_call_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   pzbi_req_if                   req_mon,
   pzbi_rsp_if                   rsp_mon,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    calls_in_flight
);

   typedef struct packed {
      logic [ZONE_W-1:0] zone;
      logic              lamp_on;
      logic [RGB_W-1:0]  rgb;
      logic              show_strobe;
   } blink_result_type;

   localparam logic [2**ZONE_W-1:0][RGB_W-1:0] ZONE_RGB = {
      24'h800080, 24'h8B0000, 24'hFF6400, 24'hFFC800,
      24'h8B4513, 24'h00FF00, 24'h0000FF, 24'h969696
   };

   limit_array_type   zone_limit;
   logic [HYST_W-1:0] hyst;

   logic [ZONE_W-1:0] held_zone;
   logic [TIME_W-1:0] blink_mark;
   logic              lit_phase;
   logic              dark_shown;
   logic [RGB_W-1:0]  pixel_rgb;

   blink_result_type  expected_q[$];
   int                failures = 0;

   assign fail_count = failures;

   function automatic blink_result_type advance_blink(
      input logic                      mode,
      input logic signed [POWER_W-1:0] power,
      input logic [CADENCE_W-1:0]      cadence,
      input logic [TIME_W-1:0]         now
   );
      blink_result_type  r;
      logic [ZONE_W-1:0] next_zone;
      int                lowered;
      int unsigned       rpm;
      logic [TIME_W-1:0] period;
      logic [TIME_W-1:0] need;
      logic [TIME_W-1:0] elapsed;
      r.show_strobe = 1'b0;
      if (mode == CALL_UPDATE) begin
         next_zone = '0;
         for (int k = 1; k <= LIMIT_COUNT; k++) begin
            lowered = int'(zone_limit[k-1]);
            if (held_zone == k)
               lowered -= int'(hyst);
            if (int'(power) > lowered)
               next_zone = ZONE_W'(k);
         end
         rpm = (cadence > SLOW_CADENCE) ? cadence : FALLBACK_RPM;
         period = MINUTE_MS / rpm;
         need = lit_phase ? LIT_MS : period - LIT_MS;
         dark_shown = 1'b0;
         held_zone = next_zone;
         elapsed = now - blink_mark;
         if (elapsed >= need) begin
            blink_mark = now;
            lit_phase = !lit_phase;
            pixel_rgb = lit_phase ? ZONE_RGB[held_zone] : '0;
            r.show_strobe = 1'b1;
         end
      end else if (!dark_shown) begin
         pixel_rgb = '0;
         dark_shown = 1'b1;
         r.show_strobe = 1'b1;
      end
      r.zone = held_zone;
      r.lamp_on = lit_phase;
      r.rgb = pixel_rgb;
      return r;
   endfunction

   task automatic check_field(input string field, input int unsigned want, input int unsigned got);
      if (want != got) begin
         failures++;
         if (failures <= 10)
            $display("mismatch on %s: expected %0d, got %0d", field, want, got);
      end
   endtask

   always @(posedge clock) begin
      blink_result_type want;
      if (reset) begin
         zone_limit = LIMIT_RESET;
         hyst = HYST_RESET;
         held_zone = '0;
         blink_mark = '0;
         lit_phase = 1'b0;
         dark_shown = 1'b1;
         pixel_rgb = '0;
         expected_q.delete();
         calls_in_flight <= 0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_HYSTERESIS)
               hyst = csr_wdata[HYST_W-1:0];
            else
               zone_limit[csr_index - CSR_ZONE_LIMIT_1] = csr_wdata;
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_q.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("result beat with nothing expected: zone %0d rgb %02h%02h%02h",
                           rsp_mon.zone, rsp_mon.red, rsp_mon.green, rsp_mon.blue);
            end else begin
               want = expected_q.pop_front();
               check_field("zone", want.zone, rsp_mon.zone);
               check_field("lamp_on", want.lamp_on, rsp_mon.lamp_on);
               check_field("red", want.rgb[23:16], rsp_mon.red);
               check_field("green", want.rgb[15:8], rsp_mon.green);
               check_field("blue", want.rgb[7:0], rsp_mon.blue);
               check_field("show_strobe", want.show_strobe, rsp_mon.show_strobe);
            end
         end
         if (req_mon.valid && req_mon.ready)
            expected_q.push_back(advance_blink(req_mon.mode, req_mon.power_watts,
                                               req_mon.cadence_rpm, req_mon.now_ms));
         calls_in_flight <= expected_q.size();
      end
   end

endmodule

// ===== tb/tb_power_zone_blink_indicator_unit.sv =====
`timescale 1ns / 1ps

module tb_power_zone_blink_indicator_unit;

   import pzbi_pkg::*;
   import pzbi_call_pkg::*;

   localparam int CYCLE_LIMIT      = 600000;
   localparam int HOLD_OFF_CYCLES  = 400;
   localparam int RANDOM_PER_PHASE = 215;
   localparam int PHASE_COUNT      = 6;
   localparam int TAIL_CYCLES      = 40;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int                    fail_count;
   int                    calls_in_flight;
   int                    cycle_count = 0;
   bit                    idle_on = 1'b1;
   int                    hold_ask = 0;
   int                    hold_seen = 0;
   logic [TIME_W-1:0]     sim_ms = '0;
   limit_array_type       limits_now = LIMIT_RESET;

   pzbi_req_if req_chan ();
   pzbi_rsp_if rsp_chan ();

   power_zone_blink_indicator_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   pzbi_call_checker u_check (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_chan),
      .rsp_mon         (rsp_chan),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .calls_in_flight (calls_in_flight)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("power_zone_blink_indicator_unit regression: fail");
         $finish;
      end
   end

   initial begin
      forever begin
         if (hold_seen != hold_ask) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_seen++;
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   task automatic send_call(
      input call_mode_type             mode,
      input logic signed [POWER_W-1:0] power,
      input logic [CADENCE_W-1:0]      cadence,
      input logic [TIME_W-1:0]         now
   );
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.mode <= mode;
      req_chan.power_watts <= power;
      req_chan.cadence_rpm <= cadence;
      req_chan.now_ms <= now;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic drain_calls();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (calls_in_flight != 0);
   endtask

   task automatic program_zones(input limit_array_type limits, input logic [HYST_W-1:0] hyst);
      drain_calls();
      for (int i = 0; i < LIMIT_COUNT; i++) begin
         csr_we <= 1'b1;
         csr_index <= CSR_IDX_W'(CSR_ZONE_LIMIT_1 + i);
         csr_wdata <= limits[i];
         @(posedge clock);
      end
      csr_we <= 1'b1;
      csr_index <= CSR_HYSTERESIS;
      csr_wdata <= CSR_DATA_W'(hyst);
      @(posedge clock);
      csr_we <= 1'b0;
      limits_now = limits;
   endtask

   task automatic random_call();
      call_mode_type             mode;
      logic signed [POWER_W-1:0] power;
      logic [CADENCE_W-1:0]      cadence;
      int                        pick;
      int                        k;
      pick = $urandom_range(0, 99);
      if (pick < 70)
         sim_ms += $urandom_range(0, 40);
      else if (pick < 93)
         sim_ms += $urandom_range(41, 2100);
      else if (pick < 97)
         sim_ms = $urandom;
      else
         sim_ms -= $urandom_range(1, 5000);
      mode = ($urandom_range(0, 7) == 0) ? CALL_DARK : CALL_UPDATE;
      pick = $urandom_range(0, 99);
      k = $urandom_range(0, LIMIT_COUNT - 1);
      if (pick < 50)
         power = POWER_W'(int'(limits_now[k]) + int'($urandom_range(0, 140)) - 70);
      else if (pick < 85)
         power = POWER_W'(int'($urandom_range(0, 2200)) - 100);
      else
         power = POWER_W'($urandom);
      cadence = ($urandom_range(0, 3) == 0) ? CADENCE_W'($urandom_range(0, 40))
                                            : CADENCE_W'($urandom);
      send_call(mode, power, cadence, sim_ms);
   endtask

   initial begin : stimulus
      limit_array_type   limits;
      logic [HYST_W-1:0] hyst;
      int                base;
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.mode <= CALL_UPDATE;
      req_chan.power_watts <= '0;
      req_chan.cadence_rpm <= '0;
      req_chan.now_ms <= '0;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_call(CALL_DARK, 0, 0, 0);
      send_call(CALL_UPDATE, 0, 0, 0);
      send_call(CALL_UPDATE, 130, 0, 899);
      send_call(CALL_UPDATE, 130, 0, 900);
      send_call(CALL_UPDATE, 123, 255, 950);
      send_call(CALL_UPDATE, 122, 255, 999);
      send_call(CALL_DARK, 500, 255, 1000);
      send_call(CALL_DARK, 500, 255, 1000);
      send_call(CALL_UPDATE, 122, 255, 1000);
      send_call(CALL_UPDATE, 32767, 31, 1135);
      send_call(CALL_UPDATE, -32768, 30, 2035);
      sim_ms = 2035;
      for (int z = 1; z <= LIMIT_COUNT; z++) begin
         repeat (2) begin
            sim_ms += 1000;
            send_call(CALL_UPDATE, POWER_W'(int'(limits_now[z-1]) + 1), 0, sim_ms);
         end
      end
      send_call(CALL_UPDATE, 0, 255, 32'hFFFF_FF00);
      send_call(CALL_UPDATE, 0, 255, 32'h0000_0010);
      sim_ms = 32'h0000_0010;

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: begin
               limits = '0;
               hyst = '1;
            end
            1: begin
               limits = '1;
               hyst = '0;
            end
            2: begin
               for (int i = 0; i < LIMIT_COUNT; i++)
                  limits[i] = LIMIT_W'(1900 - 280 * i);
               hyst = HYST_W'($urandom);
            end
            3: begin
               for (int i = 0; i < LIMIT_COUNT; i++)
                  limits[i] = LIMIT_W'($urandom_range(0, 2047));
               hyst = HYST_W'($urandom);
               sim_ms = 32'hFFFF_F000;
            end
            4: begin
               base = $urandom_range(0, 200);
               for (int i = 0; i < LIMIT_COUNT; i++) begin
                  limits[i] = LIMIT_W'(base);
                  base = base + int'($urandom_range(0, 300));
                  if (base > 2047)
                     base = 2047;
               end
               hyst = HYST_W'($urandom);
            end
            default: begin
               limits = LIMIT_RESET;
               hyst = HYST_RESET;
            end
         endcase
         program_zones(limits, hyst);
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            if (phase == 1 && n == 20)
               hold_ask <= hold_ask + 1;
            if (phase == 2 && n == RANDOM_PER_PHASE / 2)
               drain_calls();
            if (phase == PHASE_COUNT - 1 && n == RANDOM_PER_PHASE / 4)
               idle_on <= 1'b0;
            random_call();
         end
      end

      drain_calls();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("power_zone_blink_indicator_unit regression: pass");
      else
         $display("power_zone_blink_indicator_unit regression: fail");
      $finish;
   end

endmodule
